/* rtl/ps2usb_pkg.sv */
// Shared types and constants for the PS/2 packet to USB mouse report converter.
`default_nettype none

package ps2usb_pkg;

    localparam int BTN_W = 3;

    // Bit positions in the PS/2 status byte.
    localparam int STAT_MIDDLE = 2;
    localparam int STAT_X_SIGN = 4;
    localparam int STAT_Y_SIGN = 5;

    localparam logic [BTN_W-1:0] BTN_NONE   = 3'b000;
    localparam logic [BTN_W-1:0] BTN_MIDDLE = 3'b100;

    // Saturation limits of the report motion fields.
    localparam logic signed [7:0] MOTION_MAX = 8'sd127;
    localparam logic signed [7:0] MOTION_MIN = -8'sd127;

    // Motion is clamped to this range before it becomes wheel and pan.
    localparam logic signed [7:0] SCROLL_MAX = 8'sd64;
    localparam logic signed [7:0] SCROLL_MIN = -8'sd64;

    typedef struct packed {
        logic signed [7:0] delta_x;
        logic signed [7:0] delta_y;
        logic signed [3:0] wheel;
        logic signed [3:0] pan;
        logic [BTN_W-1:0]  buttons;
        logic              last_of_run;
    } t_report;

endpackage

`default_nettype wire

/* rtl/ps2_packet_to_usb_mouse_report.sv */
// Top level of the PS/2 packet to USB mouse report converter.
`default_nettype none

// Converts one three-byte PS/2 mouse packet (status, X, Y) per input beat into
// USB mouse reports. A packet is acted on only when it carries motion or its
// buttons differ from the last packet acted on. Motion becomes saturated
// -127..127 deltas with Y inverted. While the middle button is held, motion is
// turned into wheel and pan (clamped to +-64, divided by sixteen toward zero);
// releasing the middle button without having scrolled gives a middle click,
// which is two report beats: press, then release. Every packet that yields
// reports marks its final report with last_of_run. A packet is registered
// on acceptance and decoded from the input register into the single result
// register, from which its reports are taken; with the output side ready a
// new packet is taken every cycle.
// A middle-click packet occupies the result register for two output beats,
// which holds the decode stage, and the input, until the press is taken.
// The enable register (reset value one) is written through the configuration
// channel, which is always ready; when it is zero packets are absorbed with no
// reports and no change to the button or scroll state. Write it only while no
// packet is in flight.
module ps2_packet_to_usb_mouse_report
    import ps2usb_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_cfg_valid,
    output      logic               o_cfg_ready,
    input  wire logic               i_cfg_enable,

    input  wire logic               i_in_valid,
    output      logic               o_in_ready,
    input  wire logic [7:0]         i_status_byte,
    input  wire logic [7:0]         i_x_magnitude,
    input  wire logic [7:0]         i_y_magnitude,

    output      logic               o_out_valid,
    input  wire logic               i_out_ready,
    output      logic signed [7:0]  o_delta_x,
    output      logic signed [7:0]  o_delta_y,
    output      logic signed [3:0]  o_wheel,
    output      logic signed [3:0]  o_pan,
    output      logic [BTN_W-1:0]   o_buttons,
    output      logic               o_last_of_run
);

    // PS/2 nine-bit sign and magnitude to a saturated USB delta. A negative
    // value whose magnitude byte is 128 or less is beyond -127.
    function automatic logic signed [7:0] to_usb(input logic [7:0] mag, input logic neg);
        logic signed [7:0] res;
        if (neg) begin
            res = (mag > 8'd128) ? $signed(mag) : MOTION_MIN;
        end else begin
            res = (mag < 8'd128) ? $signed(mag) : MOTION_MAX;
        end
        return res;
    endfunction

    function automatic logic signed [7:0] clamp64(input logic signed [7:0] v);
        logic signed [7:0] res;
        if (v > SCROLL_MAX) begin
            res = SCROLL_MAX;
        end else if (v < SCROLL_MIN) begin
            res = SCROLL_MIN;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // Divide by sixteen, truncating toward zero; the input is within +-64.
    function automatic logic signed [3:0] div16(input logic signed [7:0] a);
        logic signed [7:0] t;
        t = a[7] ? (a + 8'sd15) : a;
        return t[7:4];
    endfunction

    // Configuration.
    logic r_enable;

    // Input register.
    logic             r_in_vld;
    logic [7:0]       r_status;
    logic [7:0]       r_xm;
    logic [7:0]       r_ym;

    // Converter state.
    logic             r_scrolled;
    logic [BTN_W-1:0] r_prev_btn;

    // Result register; r_pend means a middle release report follows the
    // report now shown.
    logic             r_out_vld;
    logic             r_pend;
    t_report          r_out;

    // Decode of the registered packet.
    logic [BTN_W-1:0]  btn;
    logic signed [7:0] x;
    logic signed [7:0] y;
    logic signed [7:0] h;
    logic signed [7:0] v_neg;
    logic              active;
    logic              can_load;
    logic              fire;
    logic              out_take;

    logic              n_out_vld;
    logic              n_pend;
    logic              n_scrolled;
    t_report           n_out;
    // The release half of a middle click.
    t_report           rel_report;

    assign o_cfg_ready = 1'b1;

    assign btn   = r_status[BTN_W-1:0];
    assign x     = to_usb(r_xm, r_status[STAT_X_SIGN]);
    assign y     = -to_usb(r_ym, r_status[STAT_Y_SIGN]);
    assign h     = clamp64(x);
    // Wheel is the negated clamped vertical motion.
    assign v_neg = -clamp64(y);

    assign active = r_enable &&
                    !((r_xm == 8'd0) && (r_ym == 8'd0) && (btn == r_prev_btn));

    assign out_take = r_out_vld && i_out_ready;
    // The decode stage may write the result register when it is empty or
    // its report leaves this cycle with nothing queued behind it.
    assign can_load = !r_out_vld || (i_out_ready && !r_pend);
    assign fire     = r_in_vld && can_load;
    assign o_in_ready = !r_in_vld || fire;

    always_comb begin
        rel_report             = '0;
        rel_report.buttons     = BTN_NONE;
        rel_report.last_of_run = 1'b1;
    end

    always_comb begin
        n_out_vld  = 1'b0;
        n_pend     = 1'b0;
        n_scrolled = r_scrolled;
        n_out      = '0;
        n_out.last_of_run = 1'b1;
        if (active) begin
            if (r_status[STAT_MIDDLE]) begin
                // Middle held: motion scrolls; no motion gives no report.
                if ((x != 8'sd0) || (y != 8'sd0)) begin
                    n_out_vld  = 1'b1;
                    n_scrolled = 1'b1;
                    n_out.wheel = div16(v_neg);
                    n_out.pan   = div16(h);
                end
            end else if (!r_scrolled && r_prev_btn[STAT_MIDDLE]) begin
                // Middle released without scrolling: a click, press first.
                n_out_vld = 1'b1;
                n_pend    = 1'b1;
                n_out.buttons     = BTN_MIDDLE;
                n_out.last_of_run = 1'b0;
            end else begin
                n_out_vld  = 1'b1;
                n_scrolled = 1'b0;
                n_out.delta_x = x;
                n_out.delta_y = y;
                n_out.buttons = btn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b1;
            r_in_vld   <= 1'b0;
            r_scrolled <= 1'b0;
            r_prev_btn <= BTN_NONE;
            r_out_vld  <= 1'b0;
            r_pend     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_enable <= i_cfg_enable;
            end

            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end

            if (fire) begin
                if (active) begin
                    r_prev_btn <= btn;
                end
                r_scrolled <= n_scrolled;
                r_out_vld  <= n_out_vld;
                r_pend     <= n_pend;
            end else if (out_take) begin
                // The release half of a click follows the press.
                r_out_vld <= r_pend;
                r_pend    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_status <= i_status_byte;
            r_xm     <= i_x_magnitude;
            r_ym     <= i_y_magnitude;
        end

        if (fire) begin
            r_out <= n_out;
        end else if (out_take && r_pend) begin
            r_out <= rel_report;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_delta_x     = r_out.delta_x;
    assign o_delta_y     = r_out.delta_y;
    assign o_wheel       = r_out.wheel;
    assign o_pan         = r_out.pan;
    assign o_buttons     = r_out.buttons;
    assign o_last_of_run = r_out.last_of_run;

endmodule

`default_nettype wire

/* rtl/ps2usb_checker.sv */
// Port-level assertions for the PS/2 to USB mouse report converter, and its bind.
`default_nettype none

module ps2usb_checker
    import ps2usb_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic signed [7:0] i_delta_x,
    input wire logic signed [7:0] i_delta_y,
    input wire logic signed [3:0] i_wheel,
    input wire logic signed [3:0] i_pan,
    input wire logic [BTN_W-1:0]  i_buttons,
    input wire logic              i_last_of_run
);

    // A shown report is not withdrawn before its beat.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat withdrawn before acceptance");

    // Only the press half of a middle click is not the last report.
    a_press_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last_of_run |->
            i_buttons == BTN_MIDDLE && i_delta_x == 8'sd0 && i_delta_y == 8'sd0 &&
            i_wheel == 4'sd0 && i_pan == 4'sd0)
        else $error("non-final report is not a middle press");

    // The press is followed at once by the release.
    a_release_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last_of_run |=>
            i_out_valid && i_last_of_run && i_buttons == BTN_NONE &&
            i_delta_x == 8'sd0 && i_delta_y == 8'sd0)
        else $error("middle press not followed by release");

    // Scroll reports carry no motion and no buttons.
    a_scroll_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_wheel != 4'sd0 || i_pan != 4'sd0) |->
            i_delta_x == 8'sd0 && i_delta_y == 8'sd0 && i_buttons == BTN_NONE)
        else $error("scroll report carries motion or buttons");

    // Motion saturates at -127, never -128.
    a_motion_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_delta_x != -8'sd128 && i_delta_y != -8'sd128)
        else $error("motion outside -127..127");

endmodule

bind ps2_packet_to_usb_mouse_report ps2usb_checker u_ps2usb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .i_delta_x     (o_delta_x),
    .i_delta_y     (o_delta_y),
    .i_wheel       (o_wheel),
    .i_pan         (o_pan),
    .i_buttons     (o_buttons),
    .i_last_of_run (o_last_of_run)
);

`default_nettype wire

/* sim/tb_ps2_packet_to_usb_mouse_report.sv */
// Self-checking testbench for the PS/2 packet to USB mouse report converter.
`default_nettype none

import ps2usb_pkg::*;

// Tracks the button and scroll state of the mouse, predicts the reports that each
// accepted packet must produce and checks the reports that come out of the block.
class mouse_report_model;
    bit               enable;
    bit               scrolled;
    logic [BTN_W-1:0] prev_buttons;
    t_report          pending_reports[$];
    int unsigned      mismatches;

    function new();
        enable       = 1'b1;
        scrolled     = 1'b0;
        prev_buttons = BTN_NONE;
        mismatches   = 0;
    endfunction

    // A sign bit with a magnitude of 128 or less saturates, as does a positive 128 or more.
    function int to_motion(logic [7:0] mag, bit neg);
        if (neg) begin
            return (mag > 8'd128) ? int'(mag) - 256 : int'(MOTION_MIN);
        end
        return (mag < 8'd128) ? int'(mag) : int'(MOTION_MAX);
    endfunction

    function int clamp_scroll(int v);
        if (v > int'(SCROLL_MAX)) begin
            return int'(SCROLL_MAX);
        end
        if (v < int'(SCROLL_MIN)) begin
            return int'(SCROLL_MIN);
        end
        return v;
    endfunction

    function void push_report(int dx, int dy, int wh, int pn, logic [BTN_W-1:0] btn,
                              bit last);
        t_report r;
        r.delta_x     = 8'(dx);
        r.delta_y     = 8'(dy);
        r.wheel       = 4'(wh);
        r.pan         = 4'(pn);
        r.buttons     = btn;
        r.last_of_run = last;
        pending_reports.push_back(r);
    endfunction

    function void note_packet(logic [7:0] status, logic [7:0] x_mag, logic [7:0] y_mag);
        logic [BTN_W-1:0] btn;
        int               dx;
        int               dy;
        int               h;
        int               v;
        btn = status[BTN_W-1:0];
        if (!enable) begin
            return;
        end
        if (x_mag == 8'd0 && y_mag == 8'd0 && btn == prev_buttons) begin
            return;
        end
        dx = to_motion(x_mag, status[STAT_X_SIGN]);
        dy = -to_motion(y_mag, status[STAT_Y_SIGN]);
        if (status[STAT_MIDDLE]) begin
            // Motion with the middle button held becomes wheel and pan.
            h = clamp_scroll(dx);
            v = clamp_scroll(dy);
            if (h != 0 || v != 0) begin
                scrolled = 1'b1;
                push_report(0, 0, -v / 16, h / 16, BTN_NONE, 1'b1);
            end
        end else if (!scrolled && (prev_buttons & BTN_MIDDLE) != BTN_NONE) begin
            // A middle release with no scrolling is a click: press, then release.
            push_report(0, 0, 0, 0, BTN_MIDDLE, 1'b0);
            push_report(0, 0, 0, 0, BTN_NONE, 1'b1);
        end else begin
            scrolled = 1'b0;
            push_report(dx, dy, 0, 0, btn, 1'b1);
        end
        prev_buttons = btn;
    endfunction

    function void check_report(t_report got);
        t_report exp;
        if (pending_reports.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected dx=%0d dy=%0d wheel=%0d pan=%0d btn=%0d last=%0b",
                     $time, got.delta_x, got.delta_y, got.wheel, got.pan, got.buttons,
                     got.last_of_run);
            return;
        end
        exp = pending_reports.pop_front();
        if (got.delta_x !== exp.delta_x || got.delta_y !== exp.delta_y ||
            got.wheel !== exp.wheel || got.pan !== exp.pan ||
            got.buttons !== exp.buttons || got.last_of_run !== exp.last_of_run) begin
            mismatches++;
            $display("%0t: expected dx=%0d dy=%0d wheel=%0d pan=%0d btn=%0d last=%0b",
                     $time, exp.delta_x, exp.delta_y, exp.wheel, exp.pan, exp.buttons,
                     exp.last_of_run);
            $display("%0t: actual   dx=%0d dy=%0d wheel=%0d pan=%0d btn=%0d last=%0b",
                     $time, got.delta_x, got.delta_y, got.wheel, got.pan, got.buttons,
                     got.last_of_run);
        end
    endfunction
endclass

module tb_ps2_packet_to_usb_mouse_report;

    // A packet passes the input register and then the result register, and a
    // middle click holds the decode stage until its press is taken, so DRAIN_CYCLES
    // are enough to be sure that a packet with no report has left the block.
    localparam int DRAIN_CYCLES  = 8;
    localparam int END_CYCLES    = 20;
    localparam int RANDOM_ITEMS  = 950;
    localparam int QUIET_FROM    = 820;
    localparam int CYCLE_LIMIT   = 600000;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_valid   = 1'b0;
    logic             i_cfg_enable  = 1'b1;
    logic             i_in_valid    = 1'b0;
    logic [7:0]       i_status_byte = 8'h00;
    logic [7:0]       i_x_magnitude = 8'h00;
    logic [7:0]       i_y_magnitude = 8'h00;
    logic             i_out_ready   = 1'b0;

    logic             o_cfg_ready;
    logic             o_in_ready;
    logic             o_out_valid;
    logic signed [7:0] o_delta_x;
    logic signed [7:0] o_delta_y;
    logic signed [3:0] o_wheel;
    logic signed [3:0] o_pan;
    logic [BTN_W-1:0] o_buttons;
    logic             o_last_of_run;

    t_report          seen_report;

    mouse_report_model model = new();

    // Set for the last part of the run, where neither side inserts random idles.
    bit               quiet_tail    = 1'b0;
    int unsigned      enabled_items = 0;
    int unsigned      cycle_count   = 0;

    ps2_packet_to_usb_mouse_report dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_enable  (i_cfg_enable),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_status_byte (i_status_byte),
        .i_x_magnitude (i_x_magnitude),
        .i_y_magnitude (i_y_magnitude),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_delta_x     (o_delta_x),
        .o_delta_y     (o_delta_y),
        .o_wheel       (o_wheel),
        .o_pan         (o_pan),
        .o_buttons     (o_buttons),
        .o_last_of_run (o_last_of_run)
    );

    always #5 i_clk = ~i_clk;

    assign seen_report = {o_delta_x, o_delta_y, o_wheel, o_pan, o_buttons, o_last_of_run};

    // Every output beat is checked against the oldest predicted report. The values
    // read here are the ones that stood before the edge, since all drivers update
    // in the nonblocking region.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            model.check_report(seen_report);
        end
    end

    // A hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // The report sink accepts for random stretches and stalls in bursts of random
    // length. Now and then a long stretch passes with no stall at all.
    initial begin
        @(posedge i_clk);
        forever begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) begin
                repeat (200) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
            if (!quiet_tail && $urandom_range(0, 1) == 1) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
        end
    end

    // Offers one packet, now and then with a random gap in front of it, and waits for its beat.
    // Valid stays high from one packet to the next when there is no gap.
    task automatic send_packet(input logic [7:0] status, input logic [7:0] x_mag,
                               input logic [7:0] y_mag);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_status_byte <= status;
        i_x_magnitude <= x_mag;
        i_y_magnitude <= y_mag;
        do @(posedge i_clk); while (!o_in_ready);
        if (model.enable) begin
            enabled_items++;
        end
        model.note_packet(status, x_mag, y_mag);
    endtask

    // The enable register is only written once the block has gone idle: every
    // predicted report has come out, and a packet that makes no report has had
    // time to pass through.
    task automatic write_enable(input bit en);
        i_in_valid <= 1'b0;
        while (model.pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid  <= 1'b1;
        i_cfg_enable <= en;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        model.enable = en;
    endtask

    // Magnitudes lean toward zero, the saturation edges and small positive and negative values.
    function automatic logic [7:0] pick_magnitude();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: begin
                case ($urandom_range(0, 4))
                    0: return 8'h01;
                    1: return 8'h7F;
                    2: return 8'h80;
                    3: return 8'h81;
                    default: return 8'hFF;
                endcase
            end
            2: return 8'($urandom_range(1, 20));
            3: return 8'($urandom_range(236, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Random ignored bits and sign bits around the given buttons.
    function automatic logic [7:0] pick_status(input logic [BTN_W-1:0] btn);
        return (8'($urandom_range(0, 255)) & 8'hC8) |
               (8'($urandom_range(0, 3)) << STAT_X_SIGN) | {5'b0, btn};
    endfunction

    // One short sequence of packets. Most are well-formed middle-button gestures
    // or motion runs with random content; the rest are arbitrary bytes.
    task automatic random_episode();
        int               steps;
        logic [BTN_W-1:0] side;
        steps = $urandom_range(1, 5);
        side  = 3'($urandom_range(0, 3));
        case ($urandom_range(0, 4))
            0: begin
                // Middle press, a few idle holds, then a release that should click.
                send_packet(pick_status(side | BTN_MIDDLE), 8'h00, 8'h00);
                repeat ($urandom_range(0, 2)) begin
                    send_packet(pick_status(3'($urandom_range(0, 3)) | BTN_MIDDLE),
                                8'h00, 8'h00);
                end
                send_packet(pick_status(3'($urandom_range(0, 3))), pick_magnitude(),
                            pick_magnitude());
            end
            1: begin
                // Middle press, scrolling, then a release that should not click.
                send_packet(pick_status(side | BTN_MIDDLE), 8'h00, 8'h00);
                repeat (steps) begin
                    send_packet(pick_status(3'($urandom_range(0, 3)) | BTN_MIDDLE),
                                pick_magnitude(), pick_magnitude());
                end
                send_packet(pick_status(3'($urandom_range(0, 3))), pick_magnitude(),
                            pick_magnitude());
            end
            2, 3: begin
                repeat (steps) begin
                    send_packet(pick_status(3'($urandom_range(0, 7))), pick_magnitude(),
                                pick_magnitude());
                end
            end
            default: begin
                repeat (steps) begin
                    send_packet(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)));
                end
            end
        endcase
    endtask

    initial begin
        int unsigned phase_end;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, with the enable register at its reset value.
        // Nothing moved and the buttons did not change: no report; then plain motion.
        send_packet(8'h00, 8'h00, 8'h00);
        send_packet(8'h00, 8'h01, 8'h00);
        send_packet(8'h00, 8'h7F, 8'h7F);
        // Positive magnitudes of 128 and above saturate.
        send_packet(8'h00, 8'h80, 8'hFF);
        // Sign bits alone are still no change.
        send_packet(8'h30, 8'h00, 8'h00);
        // Negative with a magnitude of 128 saturates; 129 is the most negative exact value.
        send_packet(8'h30, 8'h80, 8'h81);
        send_packet(8'h30, 8'hFF, 8'hFF);
        send_packet(8'h10, 8'h01, 8'h00);
        // Button changes with no motion, the ignored status bits set on the last one.
        send_packet(8'h01, 8'h00, 8'h00);
        send_packet(8'h03, 8'h00, 8'h00);
        send_packet(8'hC8, 8'h00, 8'h00);
        // Middle held without motion makes no report; the release then clicks.
        send_packet(8'h04, 8'h00, 8'h00);
        send_packet(8'h00, 8'h00, 8'h00);
        // Middle held with motion scrolls, clamped and truncated toward zero.
        send_packet(8'h04, 8'h00, 8'h00);
        send_packet(8'h04, 8'h40, 8'h00);
        send_packet(8'h24, 8'h00, 8'h0F);
        send_packet(8'h34, 8'hF1, 8'hF1);
        send_packet(8'h34, 8'hD0, 8'hF0);
        // Release after scrolling is a plain motion report.
        send_packet(8'h00, 8'h00, 8'h00);
        send_packet(8'h07, 8'h05, 8'h05);
        send_packet(8'h03, 8'h00, 8'h00);
        // A repeated middle hold is no change; adding left while held updates the
        // buttons quietly; the release with motion clicks and drops the motion.
        send_packet(8'h04, 8'h00, 8'h00);
        send_packet(8'h04, 8'h00, 8'h00);
        send_packet(8'h05, 8'h00, 8'h00);
        send_packet(8'h01, 8'h09, 8'h00);

        // With the block disabled, packets are absorbed and the state holds.
        write_enable(1'b0);
        repeat (6) random_episode();
        write_enable(1'b1);

        // Random part in phases, with a short disabled stretch between them.
        enabled_items = 0;
        while (enabled_items < RANDOM_ITEMS) begin
            phase_end = enabled_items + $urandom_range(150, 300);
            while (enabled_items < phase_end && enabled_items < RANDOM_ITEMS) begin
                quiet_tail = (enabled_items >= QUIET_FROM);
                random_episode();
            end
            if (enabled_items < RANDOM_ITEMS) begin
                write_enable(1'b0);
                repeat ($urandom_range(3, 8)) random_episode();
                write_enable(1'b1);
            end
        end

        i_in_valid <= 1'b0;
        while (model.pending_reports.size() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);

        if (model.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
